/* hw/rtl/pvs_pkg.sv */
// ----------------------------------------------------------------------------
// pvs_pkg
// Shared types, codes and saturating helpers for the profile HMM Viterbi scorer.
// ----------------------------------------------------------------------------
`default_nettype none

package pvs_pkg;

  // request codes on the command port
  localparam logic [1:0] ReqLoadTrans = 2'd0;
  localparam logic [1:0] ReqLoadEmis  = 2'd1;
  localparam logic [1:0] ReqLoadSpec  = 2'd2;
  localparam logic [1:0] ReqResidue   = 2'd3;

  // transition kinds
  localparam int TransKinds = 8;
  localparam int TMM = 0;
  localparam int TMI = 1;
  localparam int TMD = 2;
  localparam int TIM = 3;
  localparam int TII = 4;
  localparam int TDM = 5;
  localparam int TDD = 6;
  localparam int TBM = 7;

  // special score indexes
  localparam int SNLoop = 0;
  localparam int SNMove = 1;
  localparam int SELoop = 2;
  localparam int SEMove = 3;
  localparam int SCLoop = 4;
  localparam int SCMove = 5;
  localparam int SJLoop = 6;
  localparam int SJMove = 7;

  // configuration register map
  localparam int CfgAddrW = 4;
  localparam logic [1:0] RegModelLength = 2'd0;
  localparam logic [1:0] RegLocalMode   = 2'd1;
  localparam logic [1:0] RegFloorScore  = 2'd2;

  localparam logic [10:0]       ModelLengthRst = 11'd2;
  localparam logic signed [31:0] FloorScoreRst = 32'shC521974F;

  typedef struct packed {
    logic [10:0]        model_length;
    logic               local_mode;
    logic signed [31:0] floor_score;
  } cfg_t;

  typedef logic [TransKinds-1:0][31:0] trans_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SWEEP  = 5'b00010,
    ST_FIN_E  = 5'b00100,
    ST_SPEC_A = 5'b01000,
    ST_SPEC_B = 5'b10000
  } state_e;

  // widened signed add of two scores
  function automatic logic signed [32:0] add33(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    add33 = {a[31], a} + {b[31], b};
  endfunction

  function automatic logic signed [32:0] max33(input logic signed [32:0] a,
                                               input logic signed [32:0] b);
    max33 = (a > b) ? a : b;
  endfunction

  // clamp to floor..int32 max
  function automatic logic signed [31:0] clamp_cell(input logic signed [33:0] v,
                                                    input logic signed [31:0] fl);
    logic signed [33:0] flx;
    flx = {{2{fl[31]}}, fl};
    if (v < flx) clamp_cell = fl;
    else if (v > 34'sh0_7FFF_FFFF) clamp_cell = 32'sh7FFF_FFFF;
    else clamp_cell = v[31:0];
  endfunction

  // clamp of a 33-bit sum to floor..int32 max
  function automatic logic signed [31:0] clamp33(input logic signed [32:0] v,
                                                 input logic signed [31:0] fl);
    clamp33 = clamp_cell({v[32], v}, fl);
  endfunction

  // plain 32-bit saturation
  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v > 33'sh0_7FFF_FFFF) sat32 = 32'sh7FFF_FFFF;
    else if (v < -33'sh0_8000_0000) sat32 = 32'sh8000_0000;
    else sat32 = v[31:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/profile_hmm_viterbi_score_top.sv */
// ----------------------------------------------------------------------------
// profile_hmm_viterbi_score_top
// Plan7 profile HMM max-plus Viterbi scorer, one DP row per residue.
// ----------------------------------------------------------------------------
// Load commands (transition, emission, special score) keep busy low. A residue
// command sweeps nodes 1..M through the row memory at one node per cycle; busy
// stays high through the read-modify-write pass over the row memory plus the
// special-state steps. On a residue
// marked last, score_valid_o pulses for one cycle, the first cycle in which
// busy is low again; the receiver cannot stall. No clearing pass follows
// reset: row entries not yet written since the last sequence start read as
// the floor score captured at that start.
`default_nettype none

module profile_hmm_viterbi_score_top #(
  parameter int MAX_NODES      = 1024,
  parameter int ALPHABET_SLOTS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // command port
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           req_type_i,
  input  wire logic [10:0]          node_i,
  input  wire logic [2:0]           slot_i,
  input  wire logic [4:0]           residue_i,
  input  wire logic signed [31:0]   score_value_i,
  input  wire logic                 seq_first_i,
  input  wire logic                 seq_last_i,
  // result
  output logic                      score_valid_o,
  output logic signed [31:0]        viterbi_score_o,
  // configuration
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [3:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready
);
  import pvs_pkg::*;

  localparam int TaW = $clog2(MAX_NODES);
  localparam int MW  = $clog2(MAX_NODES + 1);

  cfg_t               cfg;
  logic signed [31:0] fl, esc;
  state_e             state_q, state_d;

  logic               accept, is_res;
  logic [31:0]        m32;
  logic [MW-1:0]      m, m_last, fill_q;
  logic signed [31:0] init_floor_q;
  logic [4:0]         res_q;
  logic               last_q, res_ok;

  // issue stage
  logic               iss, iss_done_q;
  logic [TaW-1:0]     idx_q;
  // read data stage
  logic               a1_v_q, a1_rowok_q, a1_last_q;
  logic [TaW-1:0]     a1_idx_q;
  // compute stage
  logic               s1_v_q, s1_last_q, s1_first_q;
  logic [TaW-1:0]     s1_idx_q;
  logic signed [32:0] msc_q, isc_q;
  logic signed [31:0] em_q, ei_q, tmd_q, tdd_q;

  logic signed [31:0] pm_q, pi_q, pd_q, nmp_q, ndp_q;
  logic signed [32:0] eacc_q;
  logic signed [31:0] e_q;
  logic signed [31:0] spec_q [TransKinds];
  logic signed [31:0] xn_q, xb_q, xj_q, xc_q;
  logic signed [31:0] score_q;
  logic               score_v_q;

  trans_t             tr;
  logic [31:0]        em_raw, ei_raw;
  logic [95:0]        row_rdata, row_wdata;
  logic               row_we;

  logic signed [31:0] om, oi, od, pm, pi, pd;
  logic signed [32:0] msc, isc;
  logic signed [31:0] nm, ni, nd, nmp, ndp;
  logic signed [32:0] ebase, eacc_d;

  pvs_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  assign fl     = cfg.floor_score;
  assign esc    = cfg.local_mode ? 32'sd0 : fl;
  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign is_res = accept && (req_type_i == ReqResidue);
  assign res_ok = (32'(res_q) < ALPHABET_SLOTS);

  // clamp model length to 2..MAX_NODES
  always_comb begin
    m32 = 32'(cfg.model_length);
    if (m32 < 32'd2) m32 = 32'd2;
    if (m32 > 32'(MAX_NODES)) m32 = 32'(MAX_NODES);
  end
  assign m      = m32[MW-1:0];
  assign m_last = m - MW'(1);

  assign iss = (state_q == ST_SWEEP) && !iss_done_q;

  pvs_tables #(.MAX_NODES(MAX_NODES), .ALPHABET_SLOTS(ALPHABET_SLOTS)) u_tables (
    .clk_i     (clk_i),
    .tr_load_i (accept && (req_type_i == ReqLoadTrans)),
    .em_load_i (accept && (req_type_i == ReqLoadEmis)),
    .node_i    (node_i),
    .slot_i    (slot_i),
    .residue_i (residue_i),
    .value_i   (score_value_i),
    .rd_en_i   (iss),
    .rd_idx_i  (idx_q),
    .rd_res_i  (res_q),
    .tr_o      (tr),
    .em_match_o(em_raw),
    .em_ins_o  (ei_raw)
  );

  // row memory: {match, insert, delete} of node idx+1
  pvs_ram #(.Width(96), .Depth(MAX_NODES)) u_row_ram (
    .clk_i  (clk_i),
    .we_i   (row_we),
    .waddr_i(s1_idx_q),
    .wdata_i(row_wdata),
    .re_i   (iss),
    .raddr_i(idx_q),
    .rdata_o(row_rdata)
  );

  // stage one: previous-row terms and best match/insert predecessors
  always_comb begin
    om  = a1_rowok_q ? $signed(row_rdata[95:64]) : init_floor_q;
    oi  = a1_rowok_q ? $signed(row_rdata[63:32]) : init_floor_q;
    od  = a1_rowok_q ? $signed(row_rdata[31:0])  : init_floor_q;
    pm  = (a1_idx_q == '0) ? fl : pm_q;
    pi  = (a1_idx_q == '0) ? fl : pi_q;
    pd  = (a1_idx_q == '0) ? fl : pd_q;
    msc = max33(max33(add33(pm, $signed(tr[TMM])), add33(pi, $signed(tr[TIM]))),
                max33(add33(pd, $signed(tr[TDM])), add33(xb_q, $signed(tr[TBM]))));
    isc = max33(add33(om, $signed(tr[TMI])), add33(oi, $signed(tr[TII])));
  end

  // stage two: new cells and running E
  always_comb begin
    nmp    = s1_first_q ? fl : nmp_q;
    ndp    = s1_first_q ? fl : ndp_q;
    nm     = clamp_cell({msc_q[32], msc_q} + {{2{em_q[31]}}, em_q}, fl);
    ni     = s1_last_q ? fl : clamp_cell({isc_q[32], isc_q} + {{2{ei_q[31]}}, ei_q}, fl);
    nd     = clamp33(max33(add33(nmp, tmd_q), add33(ndp, tdd_q)), fl);
    ebase  = s1_first_q ? {fl[31], fl} : eacc_q;
    if (s1_last_q) begin
      eacc_d = max33(max33(ebase, {nm[31], nm}), {nd[31], nd});
    end else begin
      eacc_d = max33(ebase, add33(nm, esc));
    end
  end

  assign row_we    = s1_v_q;
  assign row_wdata = {nm, ni, nd};

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (is_res) state_d = ST_SWEEP;
      ST_SWEEP:  if (s1_v_q && s1_last_q) state_d = ST_FIN_E;
      ST_FIN_E:  state_d = ST_SPEC_A;
      ST_SPEC_A: state_d = ST_SPEC_B;
      ST_SPEC_B: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      iss_done_q   <= 1'b1;
      idx_q        <= '0;
      a1_v_q       <= 1'b0;
      s1_v_q       <= 1'b0;
      fill_q       <= '0;
      init_floor_q <= FloorScoreRst;
      score_v_q    <= 1'b0;
      xn_q         <= 32'sd0;
      xb_q         <= 32'sd0;
      xj_q         <= FloorScoreRst;
      xc_q         <= FloorScoreRst;
    end else begin
      state_q   <= state_d;
      a1_v_q    <= iss;
      s1_v_q    <= a1_v_q;
      score_v_q <= (state_q == ST_SPEC_B) && last_q;
      // issue counter
      if (is_res) begin
        idx_q      <= '0;
        iss_done_q <= 1'b0;
      end else if (iss) begin
        idx_q <= idx_q + TaW'(1);
        if (MW'(idx_q) == m_last) iss_done_q <= 1'b1;
      end
      // sequence start re-initializes row zero
      if (is_res && seq_first_i) begin
        fill_q       <= '0;
        init_floor_q <= fl;
        xn_q         <= 32'sd0;
        xb_q         <= spec_q[SNMove];
        xj_q         <= fl;
        xc_q         <= fl;
      end
      if (state_q == ST_FIN_E && m > fill_q) fill_q <= m;
      // special states
      if (state_q == ST_SPEC_A) begin
        xj_q <= clamp33(max33(add33(xj_q, spec_q[SJLoop]), add33(e_q, spec_q[SELoop])), fl);
        xc_q <= clamp33(max33(add33(xc_q, spec_q[SCLoop]), add33(e_q, spec_q[SEMove])), fl);
        xn_q <= clamp33(add33(xn_q, spec_q[SNLoop]), fl);
      end
      if (state_q == ST_SPEC_B) begin
        xb_q <= clamp33(max33(add33(xn_q, spec_q[SNMove]), add33(xj_q, spec_q[SJMove])), fl);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept && req_type_i == ReqLoadSpec) spec_q[slot_i] <= score_value_i;
    if (is_res) begin
      res_q  <= residue_i;
      last_q <= seq_last_i;
    end
    a1_idx_q   <= idx_q;
    a1_rowok_q <= (MW'(idx_q) < fill_q);
    a1_last_q  <= (MW'(idx_q) == m_last);
    if (a1_v_q) begin
      s1_idx_q   <= a1_idx_q;
      s1_last_q  <= a1_last_q;
      s1_first_q <= (a1_idx_q == '0);
      msc_q      <= msc;
      isc_q      <= isc;
      em_q       <= res_ok ? $signed(em_raw) : 32'sd0;
      ei_q       <= res_ok ? $signed(ei_raw) : 32'sd0;
      tmd_q      <= $signed(tr[TMD]);
      tdd_q      <= $signed(tr[TDD]);
      pm_q       <= om;
      pi_q       <= oi;
      pd_q       <= od;
    end
    if (s1_v_q) begin
      nmp_q  <= nm;
      ndp_q  <= nd;
      eacc_q <= eacc_d;
    end
    if (state_q == ST_FIN_E) e_q <= clamp33(eacc_q, fl);
    if (state_q == ST_SPEC_B) score_q <= sat32(add33(xc_q, spec_q[SCMove]));
  end

  assign score_valid_o   = score_v_q;
  assign viterbi_score_o = score_q;

  // checks
  a_row_write_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_we |-> state_q == ST_SWEEP)
    else $error("row write outside sweep");

  a_issue_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss |-> MW'(idx_q) <= m_last)
    else $error("row index past model length");

  a_score_after_spec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    score_v_q |-> $past(state_q) == ST_SPEC_B)
    else $error("score strobe without special step");

  a_pipe_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a1_v_q || s1_v_q) |-> state_q == ST_SWEEP)
    else $error("pipeline active outside sweep");

endmodule

`default_nettype wire

/* hw/rtl/pvs_ram.sv */
// ----------------------------------------------------------------------------
// pvs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pvs_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/pvs_cfg.sv */
// ----------------------------------------------------------------------------
// pvs_cfg
// APB-style configuration registers: model length, local mode, floor score.
// ----------------------------------------------------------------------------
`default_nettype none

module pvs_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pvs_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  output pvs_pkg::cfg_t                      cfg_o
);
  import pvs_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg_o   = cfg_q;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegModelLength: cfg_d.model_length = pwdata[10:0];
        RegLocalMode:   cfg_d.local_mode   = pwdata[0];
        RegFloorScore:  cfg_d.floor_score  = $signed(pwdata);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.model_length <= ModelLengthRst;
      cfg_q.local_mode   <= 1'b1;
      cfg_q.floor_score  <= FloorScoreRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      RegModelLength: prdata = {21'd0, cfg_q.model_length};
      RegLocalMode:   prdata = {31'd0, cfg_q.local_mode};
      RegFloorScore:  prdata = cfg_q.floor_score;
      default:        prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/pvs_tables.sv */
// ----------------------------------------------------------------------------
// pvs_tables
// Transition and emission score memories with load decode and sweep reads.
// ----------------------------------------------------------------------------
`default_nettype none

module pvs_tables #(
  parameter int MAX_NODES      = 1024,
  parameter int ALPHABET_SLOTS = 32,
  localparam int TaW = $clog2(MAX_NODES)
) (
  input  wire logic               clk_i,
  input  wire logic               tr_load_i,
  input  wire logic               em_load_i,
  input  wire logic [10:0]        node_i,
  input  wire logic [2:0]         slot_i,
  input  wire logic [4:0]         residue_i,
  input  wire logic [31:0]        value_i,
  input  wire logic               rd_en_i,
  input  wire logic [TaW-1:0]     rd_idx_i,
  input  wire logic [4:0]         rd_res_i,
  output pvs_pkg::trans_t         tr_o,
  output logic      [31:0]        em_match_o,
  output logic      [31:0]        em_ins_o
);
  import pvs_pkg::*;

  localparam int EmDepth = ALPHABET_SLOTS * MAX_NODES;
  localparam int EaW     = $clog2(EmDepth);

  logic           tr_ok, em_ok;
  logic [TaW-1:0] tr_waddr, rd_next;
  logic [31:0]    em_wa32, em_ra32;

  // load range checks
  assign tr_ok    = tr_load_i && (32'(node_i) < MAX_NODES);
  assign em_ok    = em_load_i && (node_i != 11'd0) && (32'(node_i) <= MAX_NODES) &&
                    (slot_i[2:1] == 2'b00) && (32'(residue_i) < ALPHABET_SLOTS);
  assign tr_waddr = node_i[TaW-1:0];
  assign rd_next  = rd_idx_i + TaW'(1);
  assign em_wa32  = 32'(residue_i) * 32'(MAX_NODES) + 32'(node_i) - 32'd1;
  assign em_ra32  = 32'(rd_res_i) * 32'(MAX_NODES) + 32'(rd_idx_i);

  // one memory per transition kind; insert-bound kinds read the next node
  for (genvar g = 0; g < TransKinds; g++) begin : g_tr
    localparam bit NextNode = (g == TMI) || (g == TII);
    pvs_ram #(.Width(32), .Depth(MAX_NODES)) u_tr_ram (
      .clk_i  (clk_i),
      .we_i   (tr_ok && (32'(slot_i) == g)),
      .waddr_i(tr_waddr),
      .wdata_i(value_i),
      .re_i   (rd_en_i),
      .raddr_i(NextNode ? rd_next : rd_idx_i),
      .rdata_o(tr_o[g])
    );
  end

  // match and insert emissions
  pvs_ram #(.Width(32), .Depth(EmDepth)) u_em_match_ram (
    .clk_i  (clk_i),
    .we_i   (em_ok && !slot_i[0]),
    .waddr_i(em_wa32[EaW-1:0]),
    .wdata_i(value_i),
    .re_i   (rd_en_i),
    .raddr_i(em_ra32[EaW-1:0]),
    .rdata_o(em_match_o)
  );

  pvs_ram #(.Width(32), .Depth(EmDepth)) u_em_ins_ram (
    .clk_i  (clk_i),
    .we_i   (em_ok && slot_i[0]),
    .waddr_i(em_wa32[EaW-1:0]),
    .wdata_i(value_i),
    .re_i   (rd_en_i),
    .raddr_i(em_ra32[EaW-1:0]),
    .rdata_o(em_ins_o)
  );

endmodule

`default_nettype wire
